### rtl/edfa_pkg.sv
// ----------------------------------------------------------------------------
// edfa_pkg - shared types and constants
// Word layouts, fixed-point sizes and rounding constants for the exact
// binary16 dot-product accumulator.
// ----------------------------------------------------------------------------
package edfa_pkg;

  // term bound per dot product
  localparam int MAX_TERMS = 1048576;

  // binary16 fields
  localparam int MAN_W   = 10;
  localparam int EXP_W   = 5;
  localparam int HALF_W  = 1 + EXP_W + MAN_W;
  localparam int SIG_W   = MAN_W + 1;
  localparam logic [EXP_W-1:0] EXP_SPECIAL = '1;

  // operand as integer in 2^-24 units: significand << (e-1), e-1 at most 29
  localparam int ESH_W     = EXP_W;
  localparam int MAX_ESH   = 29;
  localparam int SHIFT_W   = ESH_W + 1;
  localparam int PSIG_W    = 2 * SIG_W;
  localparam int PROD_W    = PSIG_W + 2 * MAX_ESH;

  // term counter and accumulator (48 fraction bits, sign, growth)
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int ACC_W     = PROD_W + CNT_W + 1;

  // leading-one search
  localparam int CHUNK_W   = 8;
  localparam int POS_W     = $clog2(CHUNK_W);
  localparam int NCH       = (ACC_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W     = NCH * CHUNK_W;
  localparam int CIDX_W    = $clog2(NCH);
  localparam int TOP_W     = CIDX_W + POS_W;

  // rounding: magnitudes below 2^-14 (bit 34 of the 2^-48 scale) are subnormal
  localparam int SUB_TOP   = 34;
  localparam int SUB_SHIFT = 24;
  localparam int FIELD_W   = 17;
  localparam logic [FIELD_W-1:0] INF_FIELD = FIELD_W'(17'h07c00);

  // decoupling queue
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    logic              last_term;
  } item_t;

  typedef struct packed {
    logic [HALF_W-1:0] result_half;
    logic              invalid_seen;
    logic              too_many_terms;
  } result_t;

  // classified term handed from front to back
  typedef struct packed {
    logic [SIG_W-1:0]   sig_a;
    logic [SIG_W-1:0]   sig_b;
    logic [SHIFT_W-1:0] shift;
    logic               neg;
    logic               add;
    logic               last;
    logic               inv;
    logic               over;
  } term_t;

  // finished exact sum handed to the rounder
  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic             inv;
    logic             over;
  } sum_t;

endpackage

### rtl/exact_fp16_dot_accumulator.sv
// ----------------------------------------------------------------------------
// exact_fp16_dot_accumulator - exact binary16 dot product
// Sums exact products of binary16 pairs in a wide fixed-point accumulator
// and rounds once, nearest even, at the end of each dot product.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (item_valid / item_stall / item): one word is an operand
//    pair and a last_term mark. One word may be taken every cycle.
//  - Output channel (result_valid / result_stall / result): one word per
//    dot product, sent after the word marked last_term; other words give none.
//  - result_valid rises once the last word has passed, in order, the input
//    register, queue slot, product, align, accumulate, four rounding stages
//    and the result register; result_stall can hold it on the way.
//  - Throughput is one word per cycle unless stalled, set by the single wide accumulator add.
//  - A NaN or Inf operand skips its term and raises invalid_seen; terms past
//    the bound are skipped and raise too_many_terms.
//  - When result_stall holds a result, the back pipeline freezes; the queue
//    and input register then fill, and item_stall rises after at most three
//    more words.
//  - Synchronous reset clears the accumulator, count, flags and all valids;
//    item_stall is low straight after reset.
// ----------------------------------------------------------------------------
module exact_fp16_dot_accumulator (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  edfa_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output edfa_pkg::result_t result
);
  import edfa_pkg::*;

  logic   push, q_full, q_valid, pop, advance, sum_valid;
  term_t  fterm, head;
  sum_t   sum;

  edfa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .term       (fterm)
  );

  edfa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_term (fterm),
    .q_full  (q_full),
    .q_valid (q_valid),
    .pop     (pop),
    .head    (head)
  );

  edfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  edfa_round u_round (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum          (sum),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### rtl/edfa_front.sv
// ----------------------------------------------------------------------------
// edfa_front - input stage and term classifier
// Accepts operand pairs, decodes the binary16 operands, keeps the term count
// and sticky flags of the running dot product, and feeds the queue.
// ----------------------------------------------------------------------------
module edfa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  edfa_pkg::item_t item,
  input  logic           q_full,
  output logic           push,
  output edfa_pkg::term_t term
);
  import edfa_pkg::*;

  logic             fvalid;
  logic [CNT_W-1:0] cnt;
  logic             inv_flag;
  logic             over_flag;
  logic             accept;

  logic [EXP_W-1:0] ea, eb;
  logic [ESH_W-1:0] sha, shb;
  logic             bad;
  logic             over_now;
  term_t            term_next;

  assign item_stall = fvalid & q_full;
  assign push       = fvalid & ~q_full;
  assign accept     = item_valid & ~item_stall;

  always_comb begin
    ea       = item.a_half[HALF_W-2 -: EXP_W];
    eb       = item.b_half[HALF_W-2 -: EXP_W];
    bad      = (ea == EXP_SPECIAL) || (eb == EXP_SPECIAL);
    over_now = (cnt == CNT_W'(MAX_TERMS));
    sha      = (ea == '0) ? '0 : ea - ESH_W'(1);
    shb      = (eb == '0) ? '0 : eb - ESH_W'(1);

    term_next.sig_a = {ea != '0, item.a_half[MAN_W-1:0]};
    term_next.sig_b = {eb != '0, item.b_half[MAN_W-1:0]};
    term_next.shift = SHIFT_W'(sha) + SHIFT_W'(shb);
    term_next.neg   = item.a_half[HALF_W-1] ^ item.b_half[HALF_W-1];
    term_next.add   = ~over_now & ~bad;
    term_next.last  = item.last_term;
    term_next.inv   = inv_flag | bad;
    term_next.over  = over_flag | over_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid    <= 1'b0;
      cnt       <= '0;
      inv_flag  <= 1'b0;
      over_flag <= 1'b0;
    end else begin
      if (accept) begin
        fvalid <= 1'b1;
      end else if (push) begin
        fvalid <= 1'b0;
      end
      if (accept) begin
        if (item.last_term) begin
          cnt       <= '0;
          inv_flag  <= 1'b0;
          over_flag <= 1'b0;
        end else begin
          cnt       <= over_now ? cnt : cnt + CNT_W'(1);
          inv_flag  <= term_next.inv;
          over_flag <= term_next.over;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      term <= term_next;
    end
  end

endmodule

### rtl/edfa_queue.sv
// ----------------------------------------------------------------------------
// edfa_queue - term queue
// Short FIFO of classified terms between the front and the back, so that
// either side can hold without stopping the other at once.
// ----------------------------------------------------------------------------
module edfa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  edfa_pkg::term_t wr_term,
  output logic           q_full,
  output logic           q_valid,
  input  logic           pop,
  output edfa_pkg::term_t head
);
  import edfa_pkg::*;

  term_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_term;
    end
  end

endmodule

### rtl/edfa_back.sv
// ----------------------------------------------------------------------------
// edfa_back - product and accumulate pipeline
// Multiplies the significands, aligns and signs the exact product, and adds
// it into the wide accumulator. The last term of a dot product hands the
// finished sum to the rounder and clears the accumulator.
// ----------------------------------------------------------------------------
module edfa_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            q_valid,
  input  edfa_pkg::term_t head,
  output logic            pop,
  output logic            sum_valid,
  output edfa_pkg::sum_t  sum
);
  import edfa_pkg::*;

  // product stage
  logic               v1;
  logic [PSIG_W-1:0]  prod1;
  logic [SHIFT_W-1:0] shift1;
  logic               neg1, add1, last1, inv1, over1;

  // aligned term stage
  logic               v2;
  logic [ACC_W-1:0]   term2;
  logic               last2, inv2, over2;

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   aligned;
  logic [ACC_W-1:0]   term2_next;
  logic [ACC_W-1:0]   acc_sum;

  assign pop = advance & q_valid;

  always_comb begin
    aligned    = add1 ? (ACC_W'(prod1) << shift1) : '0;
    term2_next = neg1 ? (~aligned + ACC_W'(1)) : aligned;
    acc_sum    = acc + term2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      sum_valid <= 1'b0;
      acc       <= '0;
    end else if (advance) begin
      v1        <= q_valid;
      v2        <= v1;
      sum_valid <= v2 & last2;
      if (v2) begin
        acc <= last2 ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod1  <= PSIG_W'(head.sig_a) * PSIG_W'(head.sig_b);
      shift1 <= head.shift;
      neg1   <= head.neg;
      add1   <= head.add;
      last1  <= head.last;
      inv1   <= head.inv;
      over1  <= head.over;

      term2  <= term2_next;
      last2  <= last1;
      inv2   <= inv1;
      over2  <= over1;

      sum.sum  <= acc_sum;
      sum.inv  <= inv2;
      sum.over <= over2;
    end
  end

endmodule

### rtl/edfa_round.sv
// ----------------------------------------------------------------------------
// edfa_round - round to binary16
// Pipelined conversion of the exact sum to binary16, nearest even: absolute
// value, per-byte leading one, leading-one select, shift with guard and
// sticky, then increment and pack. Ends in the result register.
// ----------------------------------------------------------------------------
module edfa_round (
  input  logic              clk,
  input  logic              rst,
  input  logic              sum_valid,
  input  edfa_pkg::sum_t    sum,
  output logic              advance,
  output logic              result_valid,
  input  logic              result_stall,
  output edfa_pkg::result_t result
);
  import edfa_pkg::*;

  // stage 1: sign and magnitude
  logic             v1, sign1, inv1, over1;
  logic [ACC_W-1:0] mag1;
  // stage 2: byte flags
  logic             v2, sign2, inv2, over2;
  logic [PAD_W-1:0] mag2;
  logic [NCH-1:0]   nz2;
  logic [POS_W-1:0] pos2 [NCH];
  // stage 3: leading-one index
  logic             v3, sign3, inv3, over3;
  logic [PAD_W-1:0] mag3;
  logic [TOP_W-1:0] top3;
  // stage 4: shifted significand
  logic             v4, sign4, inv4, over4, normal4, guard4, sticky4;
  logic [SIG_W-1:0] q4;
  logic [TOP_W-1:0] top4;

  logic [PAD_W-1:0]   pad1;
  logic [NCH-1:0]     nz_next;
  logic [POS_W-1:0]   pos_next [NCH];
  logic [TOP_W-1:0]   top_next;
  logic               normal3;
  logic [TOP_W-1:0]   sm1;
  logic [PAD_W-1:0]   shifted, low_mask;
  logic               inc;
  logic [SIG_W:0]     m;
  logic [FIELD_W-1:0] field, field_sat;

  assign advance = ~result_valid | ~result_stall;

  always_comb begin
    pad1 = PAD_W'(mag1);
    for (int c = 0; c < NCH; c++) begin
      nz_next[c]  = |pad1[c*CHUNK_W +: CHUNK_W];
      pos_next[c] = '0;
      for (int j = 0; j < CHUNK_W; j++) begin
        if (pad1[c*CHUNK_W + j]) begin
          pos_next[c] = POS_W'(j);
        end
      end
    end

    top_next = '0;
    for (int c = 0; c < NCH; c++) begin
      if (nz2[c]) begin
        top_next = {CIDX_W'(c), pos2[c]};
      end
    end

    // below the normal range the step is fixed at 2^-24
    normal3  = (top3 >= TOP_W'(SUB_TOP));
    sm1      = (normal3 ? top3 - TOP_W'(MAN_W) : TOP_W'(SUB_SHIFT)) - TOP_W'(1);
    shifted  = mag3 >> sm1;
    low_mask = ~({PAD_W{1'b1}} << sm1);

    inc   = guard4 & (sticky4 | q4[0]);
    m     = {1'b0, q4} + (SIG_W + 1)'(inc);
    // carry out of the significand rolls into the exponent on its own
    field = normal4 ? ((FIELD_W'(top4) - FIELD_W'(SUB_TOP)) << MAN_W) + FIELD_W'(m)
                    : FIELD_W'(m);
    field_sat = (field >= INF_FIELD) ? INF_FIELD : field;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1           <= sum_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      result_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sign1 <= sum.sum[ACC_W-1];
      mag1  <= sum.sum[ACC_W-1] ? (~sum.sum + ACC_W'(1)) : sum.sum;
      inv1  <= sum.inv;
      over1 <= sum.over;

      sign2 <= sign1;
      mag2  <= pad1;
      nz2   <= nz_next;
      pos2  <= pos_next;
      inv2  <= inv1;
      over2 <= over1;

      sign3 <= sign2;
      mag3  <= mag2;
      top3  <= top_next;
      inv3  <= inv2;
      over3 <= over2;

      sign4   <= sign3;
      q4      <= shifted[SIG_W:1];
      guard4  <= shifted[0];
      sticky4 <= |(mag3 & low_mask);
      normal4 <= normal3;
      top4    <= top3;
      inv4    <= inv3;
      over4   <= over3;

      result.result_half    <= {sign4, field_sat[HALF_W-2:0]};
      result.invalid_seen   <= inv4;
      result.too_many_terms <= over4;
    end
  end

endmodule

### rtl/edfa_checker.sv
// ----------------------------------------------------------------------------
// edfa_checker - port checks
// Watches the top level ports: reset state, held results, result coding, stalls.
// ----------------------------------------------------------------------------
module edfa_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input edfa_pkg::result_t result
);
  import edfa_pkg::*;

  // nothing pending and input open straight after reset
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("state not clear after reset");

  // a held result word stays put
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // overflow saturates to infinity, never a NaN code
  a_no_nan: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.result_half[HALF_W-2 -: EXP_W] != EXP_SPECIAL) ||
                     (result.result_half[MAN_W-1:0] == '0))
    else $error("result is a NaN pattern");

  // the input side never stalls unless a word was offered or it stalled already
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> $past(item_valid) || $past(item_stall))
    else $error("input stalled without pending words");

endmodule

bind exact_fp16_dot_accumulator edfa_checker u_checker (.*);

### test/tb_exact_fp16_dot_accumulator.sv
// ----------------------------------------------------------------------------
// tb_exact_fp16_dot_accumulator - self-checking bench for the exact dot product
// Drives binary16 operand pairs under random bursts and gaps, stalls the
// result side on shifting patterns (with one long hold-off), and checks every
// result word against a hand-checked value or a bit-exact wide-accumulator predictor.
// ----------------------------------------------------------------------------
module tb_exact_fp16_dot_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  import edfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int          SETTLE_CYC  = 16;
  localparam int          HOLD_CYC    = 300;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic        last;
    logic        typed;
    result_t     exp;
  } drow_t;

  localparam result_t NONE = '0;

  // hand-checked results only where obvious; the rest go through the predictor
  localparam drow_t DIRECTED [25] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{16'h3c00, 16'h3c00, 1'b1, 1'b1, '{16'h3c00, 1'b0, 1'b0}},
    '{16'h7bff, 16'h7bff, 1'b1, 1'b1, '{16'h7c00, 1'b0, 1'b0}},
    '{16'hfbff, 16'h7bff, 1'b1, 1'b1, '{16'hfc00, 1'b0, 1'b0}},
    '{16'h8000, 16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{16'h7c00, 16'h3c00, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{16'hffff, 16'hffff, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{16'h3c00, 16'h3c00, 1'b0, 1'b0, NONE},
    '{16'hbc00, 16'h3c00, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{16'h7bff, 16'h7bff, 1'b0, 1'b0, NONE},
    '{16'hfbff, 16'h7bff, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{16'h0001, 16'h0001, 1'b1, 1'b0, NONE},
    '{16'h8001, 16'h0001, 1'b1, 1'b0, NONE},
    '{16'h03ff, 16'h03ff, 1'b1, 1'b0, NONE},
    '{16'h0400, 16'h3c00, 1'b1, 1'b1, '{16'h0400, 1'b0, 1'b0}},
    '{16'h03ff, 16'h3c00, 1'b0, 1'b0, NONE},
    '{16'h0001, 16'h3800, 1'b1, 1'b0, NONE},
    '{16'h3c01, 16'h3c01, 1'b1, 1'b0, NONE},
    '{16'h7bff, 16'h3c00, 1'b0, 1'b0, NONE},
    '{16'h4c00, 16'h3c00, 1'b1, 1'b0, NONE},
    '{16'hfe00, 16'h3c00, 1'b0, 1'b0, NONE},
    '{16'h3c00, 16'h4000, 1'b1, 1'b0, NONE},
    '{16'hc000, 16'hc000, 1'b1, 1'b1, '{16'h4400, 1'b0, 1'b0}},
    '{16'h7c00, 16'h0000, 1'b0, 1'b0, NONE},
    '{16'h0400, 16'h8400, 1'b1, 1'b0, NONE}
  };

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item_word;
  logic    result_valid;
  logic    result_stall;
  result_t result_word;

  exact_fp16_dot_accumulator dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result_word)
  );

  // predictor state: 2^-48 fixed point, two's complement
  logic [127:0] dot_acc     = '0;
  int unsigned  dot_terms   = 0;
  logic         dot_invalid = 1'b0;

  result_t     pending_results [$];
  int unsigned fails     = 0;
  int unsigned cycle_cnt = 0;

  bit hold_req   = 1'b0;
  bit idle_on    = 1'b0;
  int gap_max    = 1;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("exact_fp16_dot_accumulator: mismatch");
      $finish;
    end
  end

  // operand as integer in 2^-24 units
  function automatic logic [127:0] half_units(logic [15:0] h);
    if (h[14:10] != 5'd0) return 128'({1'b1, h[9:0]}) << (h[14:10] - 5'd1);
    return 128'(h[9:0]);
  endfunction

  // v / 2^s, nearest even
  function automatic logic [127:0] rne(logic [127:0] v, int s);
    logic [127:0] q;
    logic         guard;
    logic         sticky;
    q      = v >> s;
    guard  = v[s-1];
    sticky = |(v & ((128'd1 << (s - 1)) - 128'd1));
    return q + ((guard && (sticky || q[0])) ? 128'd1 : 128'd0);
  endfunction

  function automatic logic [15:0] round_dot(logic [127:0] s);
    logic [127:0] mag;
    logic [127:0] m;
    logic         neg;
    int           top;
    if (s == '0) return 16'h0000;
    neg = s[127];
    mag = neg ? -s : s;
    if (mag < (128'd1 << SUB_TOP)) return {neg, 15'(rne(mag, SUB_SHIFT))};
    top = 0;
    for (int i = 0; i < 128; i++)
      if (mag[i]) top = i;
    m = rne(mag, top - MAN_W);
    if (m == 128'd2048) begin
      m = 128'd1024;
      top++;
    end
    if (top - 33 >= 31) return {neg, 15'h7c00};
    return {neg, 5'(top - 33), 10'(m - 128'd1024)};
  endfunction

  task automatic fold_pair(input item_t w, output bit done, output result_t res);
    logic [127:0] prod;
    logic         bad;
    bad  = (w.a_half[14:10] == EXP_SPECIAL) || (w.b_half[14:10] == EXP_SPECIAL);
    done = 1'b0;
    res  = '0;
    if (dot_terms >= MAX_TERMS) begin
      dot_terms = MAX_TERMS + 1;
      if (bad) dot_invalid = 1'b1;
    end else begin
      dot_terms++;
      if (bad) begin
        dot_invalid = 1'b1;
      end else begin
        prod = half_units(w.a_half) * half_units(w.b_half);
        if (w.a_half[15] ^ w.b_half[15]) prod = -prod;
        dot_acc = dot_acc + prod;
      end
    end
    if (w.last_term) begin
      done               = 1'b1;
      res.result_half    = round_dot(dot_acc);
      res.invalid_seen   = dot_invalid;
      res.too_many_terms = (dot_terms > MAX_TERMS);
      dot_acc            = '0;
      dot_terms          = 0;
      dot_invalid        = 1'b0;
    end
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer(input item_t w, input bit typed, input result_t exp);
    bit      done;
    result_t res;
    if (idle_on) begin
      if (burst_left == 0) begin
        item_valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    item_word  = w;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    fold_pair(w, done, res);
    if (done) pending_results.insert(pending_results.size(), typed ? exp : res);
    @(negedge clk);
  endtask

  task automatic settle();
    item_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5: h[14:10] = 5'($urandom_range(12, 18));
      6: h[14:10] = 5'd0;
      7: h[14:10] = 5'($urandom_range(27, 30));
      8: h[14:10] = EXP_SPECIAL;
      default: h[14:0] = $urandom_range(0, 1) ? 15'h3c00 : 15'h0000;
    endcase
    return h;
  endfunction

  // dot products of random length; some terms cancel the one before exactly
  task automatic random_products(input int n);
    int          sent;
    int          len;
    logic [15:0] pa;
    logic [15:0] pb;
    sent = 0;
    pa   = '0;
    pb   = '0;
    while (sent < n) begin
      if ($urandom_range(0, 3) == 0) begin
        idle_on = $urandom_range(0, 1);
        gap_max = $urandom_range(1, 8);
      end
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if (k > 0 && $urandom_range(0, 5) == 0) begin
          pa = pa ^ 16'h8000;
        end else begin
          pa = rand_half();
          pb = rand_half();
        end
        offer(item_t'{pa, pb, (k == len - 1)}, 1'b0, NONE);
        sent++;
      end
    end
  endtask

  // result side: stall pattern redrawn when its phase counter runs out, long hold-off on request
  initial begin
    int          phase_cnt;
    int          mode;
    logic [7:0]  mask;
    phase_cnt    = 0;
    mode         = 0;
    mask         = 8'b1100_1010;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall = 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
      end
      if (phase_cnt == 0) begin
        mode      = $urandom_range(0, 3);
        mask      = 8'($urandom);
        phase_cnt = 64;
      end
      phase_cnt--;
      mask = {mask[6:0], mask[7]};
      case (mode)
        0: result_stall = 1'b0;
        1: result_stall = ($urandom_range(0, 3) == 0);
        2: result_stall = ($urandom_range(0, 3) != 0);
        default: result_stall = mask[0];
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", result_word);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (result_word.result_half !== want.result_half) begin
          $error("result_half: expected %h, got %h", want.result_half,
                 result_word.result_half);
          fails++;
        end
        if (result_word.invalid_seen !== want.invalid_seen) begin
          $error("invalid_seen: expected %b, got %b", want.invalid_seen,
                 result_word.invalid_seen);
          fails++;
        end
        if (result_word.too_many_terms !== want.too_many_terms) begin
          $error("too_many_terms: expected %b, got %b", want.too_many_terms,
                 result_word.too_many_terms);
          fails++;
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item_word  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    idle_on = 1'b1;
    gap_max = 3;
    foreach (DIRECTED[i])
      offer(item_t'{DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].last},
            DIRECTED[i].typed, DIRECTED[i].exp);
    settle();

    random_products(350);
    settle();

    // receiver holds off while single-term products keep coming
    hold_req = 1'b1;
    idle_on  = 1'b0;
    repeat (30) offer(item_t'{rand_half(), rand_half(), 1'b1}, 1'b0, NONE);
    settle();

    random_products(300);
    settle();

    random_products(20);
    settle();

    if (fails == 0) begin
      $display("exact_fp16_dot_accumulator: match");
    end else begin
      $display("exact_fp16_dot_accumulator: mismatch");
    end
    $finish;
  end

endmodule

### exact_fp16_dot_accumulator.f
rtl/edfa_pkg.sv
rtl/edfa_front.sv
rtl/edfa_queue.sv
rtl/edfa_back.sv
rtl/edfa_round.sv
rtl/exact_fp16_dot_accumulator.sv
rtl/edfa_checker.sv
test/tb_exact_fp16_dot_accumulator.sv
